@@ rtl/dq_pkg.sv @@
`timescale 1ns / 1ps

package dq_pkg;

    localparam int DEPTH_DEF = 32;

    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;

    // result tdata: item_value, item_count, zero pad to whole bytes
    localparam int M_TDATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - VALUE_W - COUNT_W;

    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_kind KIND_PUSH_FRONT = 3'd0;
    localparam t_kind KIND_PUSH_BACK  = 3'd1;
    localparam t_kind KIND_POP_FRONT  = 3'd2;
    localparam t_kind KIND_POP_BACK   = 3'd3;
    localparam t_kind KIND_LIST       = 3'd4;

    localparam t_status STAT_OK    = 2'd0;
    localparam t_status STAT_EMPTY = 2'd1;
    localparam t_status STAT_FULL  = 2'd2;

endpackage

@@ rtl/dq_ram.sv @@
`timescale 1ns / 1ps

// Simple dual-port entry store, one write and one registered read per cycle.
module dq_ram #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(dq_pkg::DEPTH_DEF)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [dq_pkg::VALUE_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [dq_pkg::VALUE_W-1:0] o_rdata
);
    import dq_pkg::*;

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/double_ended_queue.sv @@
`timescale 1ns / 1ps
// A push or pop result goes from acceptance into the pending register, then the output register.
// Throughput: one push or pop item per cycle while results drain; a listing holds the
//   input until every stored entry is listed (one store read per listed entry).
// The store has one write and one read port, which sets the listing rate.
// Reset (synchronous, active low) empties the queue; the store itself is not cleared.
module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input items
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [dq_pkg::VALUE_W-1:0]   i_s_axis_tdata,   // [31:0] value
    input  logic [dq_pkg::KIND_W-1:0]    i_s_axis_tuser,   // [2:0] kind
    // result items
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [dq_pkg::M_TDATA_W-1:0] o_m_axis_tdata,   // [31:0] item_value,
                                                           // [37:32] item_count, pad
    output logic [dq_pkg::STATUS_W-1:0]  o_m_axis_tuser,   // [1:0] status
    output logic                         o_m_axis_tlast    // last
);
    import dq_pkg::*;

    localparam int IW = $clog2(DEPTH);        // store index
    localparam int CW = $clog2(DEPTH + 1);    // fill count, holds DEPTH itself

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LIST = 1'b1;

    // result waiting for the store read (if any) before the output register
    typedef struct packed {
        logic               use_mem;
        logic [COUNT_W-1:0] count;
        t_status            status;
        logic               last;
    } t_pend;

    // circular index: (a + b) mod DEPTH, both operands below DEPTH
    function automatic logic [IW-1:0] f_wrap(input logic [IW-1:0] a,
                                             input logic [IW-1:0] b);
        logic [IW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (IW + 1)'(DEPTH)) begin
            s = s - (IW + 1)'(DEPTH);
        end
        return s[IW-1:0];
    endfunction

    // control state
    logic          r_state, n_state;
    logic [IW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_idx,   n_idx;     // listing position from the front

    logic          r_pend_valid, n_pend_valid;
    t_pend         r_pend, n_pend;

    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic [COUNT_W-1:0] r_out_count;
    t_status            r_out_status;
    logic               r_out_last;

    // store port
    logic               ram_we, ram_re;
    logic [IW-1:0]      ram_waddr, ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    logic    pend_move, pend_free, s_acc, full, empty;
    logic    new_valid;
    t_pend   new_pend;
    logic [IW-1:0] front_dec, last_off;
    t_kind   kind;

    assign kind      = i_s_axis_tuser;
    assign pend_move = r_pend_valid && (!r_out_valid || i_m_axis_tready);
    assign pend_free = !r_pend_valid || pend_move;

    // new items only between listings and when the pending slot frees up
    assign o_s_axis_tready = (r_state == S_IDLE) && pend_free;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign front_dec = (r_front == '0) ? IW'(DEPTH - 1) : r_front - 1'b1;
    assign last_off  = IW'(r_count - 1'b1);   // offset of the back entry

    always_comb begin
        n_state   = r_state;
        n_front   = r_front;
        n_count   = r_count;
        n_idx     = r_idx;
        ram_we    = 1'b0;
        ram_waddr = r_front;
        ram_re    = 1'b0;
        ram_raddr = r_front;
        new_valid = 1'b0;
        new_pend  = '0;

        if (s_acc) begin
            case (kind)
                KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                    new_valid     = 1'b1;
                    new_pend.last = 1'b1;
                    if (full) begin
                        // queue untouched
                        new_pend.status = STAT_FULL;
                        new_pend.count  = COUNT_W'(r_count);
                    end else begin
                        ram_we = 1'b1;
                        if (kind == KIND_PUSH_FRONT) begin
                            n_front   = front_dec;
                            ram_waddr = front_dec;
                        end else begin
                            ram_waddr = f_wrap(r_front, IW'(r_count));
                        end
                        n_count         = r_count + 1'b1;
                        new_pend.status = STAT_OK;
                        new_pend.count  = COUNT_W'(n_count);
                    end
                end
                KIND_POP_FRONT, KIND_POP_BACK: begin
                    new_valid     = 1'b1;
                    new_pend.last = 1'b1;
                    if (empty) begin
                        new_pend.status = STAT_EMPTY;
                    end else begin
                        ram_re = 1'b1;
                        if (kind == KIND_POP_FRONT) begin
                            ram_raddr = r_front;
                            n_front   = f_wrap(r_front, IW'(1));
                        end else begin
                            ram_raddr = f_wrap(r_front, last_off);
                        end
                        n_count          = r_count - 1'b1;
                        new_pend.use_mem = 1'b1;
                        new_pend.status  = STAT_OK;
                        new_pend.count   = COUNT_W'(n_count);
                    end
                end
                KIND_LIST: begin
                    if (empty) begin
                        new_valid       = 1'b1;
                        new_pend.last   = 1'b1;
                        new_pend.status = STAT_EMPTY;
                    end else begin
                        n_state = S_LIST;
                        n_idx   = '0;
                    end
                end
                default: begin
                    // unused kinds are dropped without a result
                end
            endcase
        end else if (r_state == S_LIST && pend_free) begin
            // one store read per listed entry, front to back
            ram_re           = 1'b1;
            ram_raddr        = f_wrap(r_front, r_idx);
            new_valid        = 1'b1;
            new_pend.use_mem = 1'b1;
            new_pend.status  = STAT_OK;
            new_pend.count   = COUNT_W'(r_count);
            new_pend.last    = (r_idx == last_off);
            if (r_idx == last_off) begin
                n_state = S_IDLE;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        if (new_valid) begin
            n_pend_valid = 1'b1;
            n_pend       = new_pend;
        end else if (pend_move) begin
            n_pend_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_front      <= '0;
            r_count      <= '0;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_front      <= n_front;
            r_count      <= n_count;
            r_idx        <= n_idx;
            r_pend_valid <= n_pend_valid;
            if (pend_move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (pend_move) begin
            r_out_value  <= r_pend.use_mem ? ram_rdata : '0;
            r_out_count  <= r_pend.count;
            r_out_status <= r_pend.status;
            r_out_last   <= r_pend.last;
        end
    end

    dq_ram #(
        .DEPTH (DEPTH),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_s_axis_tdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{M_PAD_W{1'b0}}, r_out_count, r_out_value};
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

    // fill count never exceeds the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    // listing holds off new items
    a_list_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> !o_s_axis_tready)
        else $error("item accepted during listing");

    // a successful push grows the queue by one
    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && !full && (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK))
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not grow the queue");

    // no store read is issued while a read result still waits
    a_read_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && r_pend.use_mem && !pend_move) |-> !ram_re)
        else $error("store read overwrote a pending value");

    // error results always close their item
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != STAT_OK) |-> r_out_last)
        else $error("error result without last");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import dq_pkg::*;

    localparam int QDEPTH       = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 390;
    localparam int HOLD_CYCLES  = 400;      // long receiver hold-off, fills the block
    localparam int DRAIN_CYCLES = 16;       // settle time after the last result
    localparam int CYCLE_LIMIT  = 300000;
    localparam int MAX_REPORTS  = 10;

    // kind codes the block must drop silently
    localparam t_kind KIND_SPARE_LO  = 3'd5;
    localparam t_kind KIND_SPARE_MID = 3'd6;
    localparam t_kind KIND_SPARE_HI  = 3'd7;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        t_status            status;
        logic               last;
    } t_result;

    // one row of the directed table; typed rows carry their result inline
    typedef struct packed {
        t_kind              kind;
        logic [VALUE_W-1:0] value;
        logic               typed;
        t_result            res;
    } t_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 s_valid = 1'b0;
    logic [VALUE_W-1:0]   s_value = '0;
    t_kind                s_kind  = KIND_PUSH_FRONT;
    logic                 s_ready;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [M_TDATA_W-1:0] m_data;
    t_status              m_status;
    logic                 m_last;

    double_ended_queue #(
        .DEPTH(QDEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_value),      // [31:0] value
        .i_s_axis_tuser (s_kind),       // [2:0] kind
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),       // [31:0] item_value, [37:32] item_count, pad
        .o_m_axis_tuser (m_status),     // [1:0] status
        .o_m_axis_tlast (m_last)        // last
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Deque predictor: its own circular store, front slot and fill level.
    // Results are queued in the order the block must deliver them.
    // ------------------------------------------------------------------
    logic [VALUE_W-1:0] deque_store [QDEPTH];
    int                 front_slot = 0;
    int                 held       = 0;
    t_result            pending_results [$];

    int items_sent      = 0;
    int spare_sent      = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int full_hits       = 0;
    int empty_hits      = 0;
    int list_runs       = 0;
    int longest_list    = 0;

    function automatic t_result make_result(input logic [VALUE_W-1:0] value, input int count,
                                            input t_status status, input logic last);
        t_result r;
        r.value  = value;
        r.count  = count[COUNT_W-1:0];
        r.status = status;
        r.last   = last;
        return r;
    endfunction

    function automatic void predict_deque(input t_kind kind, input logic [VALUE_W-1:0] value);
        int i;
        case (kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                if (held >= QDEPTH) begin
                    // full: nothing moves
                    full_hits++;
                    pending_results.push_back(make_result('0, held, STAT_FULL, 1'b1));
                end else begin
                    if (kind == KIND_PUSH_FRONT) begin
                        front_slot = (front_slot + QDEPTH - 1) % QDEPTH;
                        deque_store[front_slot] = value;
                    end else begin
                        deque_store[(front_slot + held) % QDEPTH] = value;
                    end
                    held++;
                    pending_results.push_back(make_result('0, held, STAT_OK, 1'b1));
                end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
                if (held == 0) begin
                    empty_hits++;
                    pending_results.push_back(make_result('0, 0, STAT_EMPTY, 1'b1));
                end else if (kind == KIND_POP_FRONT) begin
                    held--;
                    pending_results.push_back(make_result(deque_store[front_slot], held,
                                                          STAT_OK, 1'b1));
                    front_slot = (front_slot + 1) % QDEPTH;
                end else begin
                    held--;
                    pending_results.push_back(make_result(
                        deque_store[(front_slot + held) % QDEPTH], held, STAT_OK, 1'b1));
                end
            end
            KIND_LIST: begin
                list_runs++;
                if (held > longest_list) longest_list = held;
                if (held == 0) begin
                    empty_hits++;
                    pending_results.push_back(make_result('0, 0, STAT_EMPTY, 1'b1));
                end
                for (i = 0; i < held; i++)
                    pending_results.push_back(make_result(
                        deque_store[(front_slot + i) % QDEPTH], held, STAT_OK, i + 1 == held));
            end
            default: ;  // spare kinds: dropped, no result
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every accepted result against the oldest expectation.
    // ------------------------------------------------------------------
    task automatic check_result(input t_result seen);
        t_result want;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: result with nothing pending: value %h count %0d status %0d",
                         $realtime, seen.value, seen.count, seen.status);
        end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (want.value !== seen.value || want.count !== seen.count ||
                want.status !== seen.status || want.last !== seen.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: mismatch exp value %h count %0d status %0d last %0b",
                             $realtime, want.value, want.count, want.status, want.last);
                    $display("%0t:          got value %h count %0d status %0d last %0b",
                             $realtime, seen.value, seen.count, seen.status, seen.last);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready)
            check_result(make_result(m_data[VALUE_W-1:0], int'(m_data[VALUE_W +: COUNT_W]),
                                     m_status, m_last));
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request. The
    // stimulus bumps hold_req; the countdown lives here.
    // ------------------------------------------------------------------
    int sink_stall_pct = 59;
    int src_gap_pct    = 10;
    int hold_req       = 0;
    int hold_ack       = 0;
    int hold_left      = 0;

    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // offers one item, waits for the handshake, then updates the predictor
    task automatic send_item(input t_kind kind, input logic [VALUE_W-1:0] value,
                             input logic typed, input t_result typed_res);
        int before_n;
        while ($urandom_range(99) < src_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_value <= value;
        do @(posedge i_clk); while (!s_ready);
        before_n = pending_results.size();
        predict_deque(kind, value);
        if (typed) begin
            while (pending_results.size() > before_n) void'(pending_results.pop_back());
            pending_results.push_back(typed_res);
        end
        if (kind <= KIND_LIST)
            items_sent++;
        else
            spare_sent++;
    endtask

    // mostly full-range noise, now and then an extreme
    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(15))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_kind rand_push();
        return $urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
    endfunction

    function automatic t_kind rand_pop();
        return $urandom_range(1) ? KIND_POP_FRONT : KIND_POP_BACK;
    endfunction

    // push until full, bump into the full case, maybe list all entries
    task automatic fill_burst();
        while (held < QDEPTH)
            send_item(rand_push(), rand_value(), 1'b0, '0);
        repeat ($urandom_range(2, 1))
            send_item(rand_push(), rand_value(), 1'b0, '0);
        if ($urandom_range(1))
            send_item(KIND_LIST, rand_value(), 1'b0, '0);
    endtask

    // pop until empty, then one more pop and a listing of nothing
    task automatic drain_burst();
        while (held > 0)
            send_item(rand_pop(), rand_value(), 1'b0, '0);
        send_item(rand_pop(), rand_value(), 1'b0, '0);
        send_item(KIND_LIST, rand_value(), 1'b0, '0);
    endtask

    task automatic mixed_burst();
        int r;
        repeat ($urandom_range(16, 4)) begin
            r = $urandom_range(99);
            if (r < 48)
                send_item(rand_push(), rand_value(), 1'b0, '0);
            else if (r < 84)
                send_item(rand_pop(), rand_value(), 1'b0, '0);
            else if (r < 95)
                send_item(KIND_LIST, rand_value(), 1'b0, '0);
            else
                send_item(t_kind'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO)),
                          rand_value(), 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Directed table: empty cases first, extremes of value, every kind,
    // spare kinds in between. Typed rows are the obvious ones.
    // ------------------------------------------------------------------
    t_row dir_rows [$];

    function automatic void add_row(input t_kind kind, input logic [VALUE_W-1:0] value,
                                    input logic typed, input t_result res);
        t_row row;
        row.kind  = kind;
        row.value = value;
        row.typed = typed;
        row.res   = res;
        dir_rows.push_back(row);
    endfunction

    initial begin
        int start_items;
        int done;
        logic pressure_done;

        // right after reset everything is empty
        add_row(KIND_POP_FRONT,  32'h0000_0000, 1'b1, make_result('0, 0, STAT_EMPTY, 1'b1));
        add_row(KIND_POP_BACK,   32'h1234_5678, 1'b1, make_result('0, 0, STAT_EMPTY, 1'b1));
        add_row(KIND_LIST,       32'hFFFF_FFFF, 1'b1, make_result('0, 0, STAT_EMPTY, 1'b1));
        add_row(KIND_SPARE_LO,   32'hDEAD_BEEF, 1'b0, '0);
        add_row(KIND_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1, make_result('0, 1, STAT_OK, 1'b1));
        add_row(KIND_PUSH_BACK,  32'h8000_0000, 1'b1, make_result('0, 2, STAT_OK, 1'b1));
        add_row(KIND_PUSH_FRONT, 32'h0000_0000, 1'b1, make_result('0, 3, STAT_OK, 1'b1));
        add_row(KIND_PUSH_BACK,  32'hFFFF_FFFF, 1'b1, make_result('0, 4, STAT_OK, 1'b1));
        add_row(KIND_LIST,       32'h0000_0000, 1'b0, '0);
        add_row(KIND_SPARE_MID,  32'hFFFF_FFFF, 1'b0, '0);
        add_row(KIND_POP_FRONT,  32'hAAAA_AAAA, 1'b0, '0);
        add_row(KIND_POP_BACK,   32'h5555_5555, 1'b0, '0);
        add_row(KIND_SPARE_HI,   32'h0000_0000, 1'b0, '0);
        add_row(KIND_LIST,       32'h0000_0000, 1'b0, '0);
        add_row(KIND_POP_BACK,   32'h0000_0000, 1'b0, '0);
        add_row(KIND_POP_FRONT,  32'h0000_0000, 1'b0, '0);
        add_row(KIND_POP_FRONT,  32'h0000_0000, 1'b1, make_result('0, 0, STAT_EMPTY, 1'b1));
        add_row(KIND_PUSH_BACK,  32'h5555_5555, 1'b0, '0);
        add_row(KIND_PUSH_FRONT, 32'hAAAA_AAAA, 1'b0, '0);
        add_row(KIND_LIST,       32'h0000_0000, 1'b0, '0);
        add_row(KIND_POP_BACK,   32'h0000_0000, 1'b0, '0);
        add_row(KIND_POP_BACK,   32'h0000_0000, 1'b0, '0);
        add_row(KIND_LIST,       32'h0000_0000, 1'b1, make_result('0, 0, STAT_EMPTY, 1'b1));

        // hold reset low, then release it
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].kind, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].res);

        // random part in three idling phases; the full case comes up first
        start_items   = items_sent;
        pressure_done = 1'b0;
        fill_burst();
        while (items_sent - start_items < RANDOM_ITEMS) begin
            done = items_sent - start_items;
            if (done < RANDOM_ITEMS / 3) begin
                src_gap_pct    = 10;
                sink_stall_pct = 59;
            end else if (done < 2 * RANDOM_ITEMS / 3) begin
                src_gap_pct    = 59;
                sink_stall_pct = 10;
            end else begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
                if (!pressure_done) begin
                    // receiver goes quiet while a full run of pushes keeps coming
                    pressure_done = 1'b1;
                    hold_req++;
                    fill_burst();
                end
            end
            case ($urandom_range(9))
                0:       fill_burst();
                1:       drain_burst();
                default: mixed_burst();
            endcase
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d items (%0d spare kinds dropped), %0d results checked, %0d mismatches",
                 items_sent, spare_sent, results_checked, mismatches);
        $display("full pushes %0d, empty pops/lists %0d, listings %0d, longest listing %0d",
                 full_hits, empty_hits, list_runs, longest_list);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("double_ended_queue verification clean");
        end else begin
            $display("double_ended_queue verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still pending",
                 cycle_count, pending_results.size());
        $display("double_ended_queue verification failed");
        $finish;
    end

endmodule
